// File: design/rtt_pkg.sv
// Shared constants and types for the retransmit timeout table.
package rtt_pkg;
	localparam int unsigned DEPTH_DEFAULT = 32;
	localparam int unsigned ID_W = 16;
	localparam int unsigned TIME_W = 48;
	localparam int unsigned PERIOD_W = 32;
	localparam int unsigned TALLY_W = 6;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_ACK    = 2'd1;
	localparam logic [1:0] ACT_TICK   = 2'd2;
	localparam logic [1:0] ACT_QUERY  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	typedef struct packed {
		logic              kind;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] oldest;
		logic [TALLY_W-1:0] tally;
		logic [1:0]        status;
		logic              last;
	} result_t;
endpackage

// File: design/rtt_mem.sv
// Entry store: one write port, one registered read port.
module rtt_mem import rtt_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEFAULT,
	parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [ID_W+TIME_W-1:0]    wdata,
	input  logic [AW-1:0]             raddr,
	output logic [ID_W+TIME_W-1:0]    rdata
);
	logic [ID_W+TIME_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: design/retransmit_timeout_table.sv
// Retransmit timeout table: an insert, or any action on an empty table, goes from idle straight
// to the done state, which registers its completion; the next item is taken back in idle. Ack,
// tick and query walk the held entries through the store, a read state and an evaluate state
// per entry, then the done state registers the completion. A waiting result that is stalled
// holds the evaluate and done states, and no new item is taken until the walk is done.
// Reset clears the count, the period and the output valid; the store is not cleared.
module retransmit_timeout_table import rtt_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = DEPTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          action,
	input  logic [ID_W-1:0]     packet_id,
	input  logic [TIME_W-1:0]   time_value,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [PERIOD_W-1:0] cfg_data,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                result_kind,
	output logic [ID_W-1:0]     resend_id,
	output logic [TIME_W-1:0]   oldest_time,
	output logic [TALLY_W-1:0]  tally,
	output logic [1:0]          status,
	output logic                last
);
	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [TALLY_W-1:0] DEPTH_C = TALLY_W'(TABLE_DEPTH);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1; // address issued, data next cycle
	localparam logic [2:0] S_EVAL = 3'd2; // data valid
	localparam logic [2:0] S_DONE = 3'd3;

	logic [2:0]          state_q;
	logic [1:0]          act_q;
	logic [ID_W-1:0]     id_q;
	logic [TIME_W-1:0]   tv_q;
	logic [PERIOD_W-1:0] period_q;
	logic [TALLY_W-1:0]  count_q;
	logic [TALLY_W-1:0]  idx_q;    // entry being read
	logic [TALLY_W-1:0]  resent_q;
	logic                found_q;
	logic [TIME_W-1:0]   min_q;
	result_t             res_q;
	logic                res_valid_q;

	logic                we;
	logic [AW-1:0]       waddr, raddr;
	logic [ID_W+TIME_W-1:0] wdata, rdata;
	logic [ID_W-1:0]     rd_id;
	logic [TIME_W-1:0]   rd_time;
	logic                out_free;
	logic                expired;

	assign rd_id   = rdata[ID_W+TIME_W-1:TIME_W];
	assign rd_time = rdata[TIME_W-1:0];
	assign out_free = !res_valid_q || !out_stall;
	assign expired = ({1'b0, rd_time} + {{(TIME_W+1-PERIOD_W){1'b0}}, period_q})
		< {1'b0, tv_q};

	rtt_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && !res_valid_q;

	// store control
	always_comb begin
		we = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = {rd_id, rd_time};
		raddr = idx_q[AW-1:0];
		if (state_q == S_IDLE && in_valid && action == ACT_INSERT && count_q < DEPTH_C) begin
			we = 1'b1;
			waddr = count_q[AW-1:0];
			wdata = {packet_id, time_value};
		end else if (state_q == S_EVAL && out_free) begin
			// compacting ack: write entry idx into idx-1
			if (act_q == ACT_ACK && found_q) begin
				we = 1'b1;
				waddr = AW'(idx_q - 1'b1);
			end else if (act_q == ACT_TICK && expired) begin
				we = 1'b1;
				wdata = {rd_id, tv_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			period_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !out_stall) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				period_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						act_q <= action;
						id_q <= packet_id;
						tv_q <= time_value;
						idx_q <= '0;
						resent_q <= '0;
						// for an insert, flag a full table at the transfer
						found_q <= (action == ACT_INSERT) && (count_q >= DEPTH_C);
						min_q <= '1;
						if (action == ACT_INSERT) begin
							if (count_q < DEPTH_C) begin
								count_q <= count_q + 1'b1;
							end
							state_q <= S_DONE;
						end else if (count_q == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (out_free) begin
						if (act_q == ACT_ACK && !found_q && rd_id == id_q) begin
							found_q <= 1'b1;
						end
						if (act_q == ACT_QUERY && rd_time < min_q) begin
							min_q <= rd_time;
						end
						if (act_q == ACT_TICK && expired) begin
							res_q <= '{kind: 1'b0, id: rd_id, oldest: '0, tally: '0,
								status: ST_OK, last: 1'b0};
							res_valid_q <= 1'b1;
							resent_q <= resent_q + 1'b1;
						end
						idx_q <= idx_q + 1'b1;
						state_q <= (idx_q + 1'b1 == count_q) ? S_DONE : S_READ;
					end
				end
				S_DONE: begin
					if (out_free) begin
						res_q.kind <= 1'b1;
						res_q.id <= '0;
						res_q.oldest <= '0;
						res_q.last <= 1'b1;
						res_q.status <= ST_OK;
						res_q.tally <= count_q;
						unique case (act_q)
							ACT_INSERT: begin
								if (found_q) begin
									res_q.status <= ST_FULL;
								end
							end
							ACT_ACK: begin
								if (found_q) begin
									count_q <= count_q - 1'b1;
									res_q.tally <= count_q - 1'b1;
								end else begin
									res_q.status <= ST_NOTFOUND;
								end
							end
							ACT_TICK: res_q.tally <= resent_q;
							default: begin
								if (count_q == '0) begin
									res_q.status <= ST_EMPTY;
									res_q.tally <= '0;
								end else begin
									res_q.oldest <= min_q;
								end
							end
						endcase
						res_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = res_valid_q;
	assign result_kind = res_q.kind;
	assign resend_id   = res_q.id;
	assign oldest_time = res_q.oldest;
	assign tally       = res_q.tally;
	assign status      = res_q.status;
	assign last        = res_q.last;

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C) else $error("entry count beyond depth");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && action != ACT_INSERT && count_q != '0) |=> in_stall)
		else $error("walk did not start");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(res_q)))
		else $error("result lost under stall");
endmodule
